/* hdl/sync_length_frame_deframer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sync/length frame deframer
// Shared immediate-implication and next-cycle-implication forms.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("slfd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("slfd: next-cycle check failed");

`endif

/* hdl/slfd_pkg.sv */
// ----------------------------------------------------------------------------
// slfd_pkg
// Types and constants shared by the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package slfd_pkg;

  localparam logic [31:0] SYNC_WORD       = 32'h0e19_0117;
  localparam int          HEADER_BYTES    = 48;
  localparam int          WIRE_HDR_BYTES  = 8;
  localparam logic [23:0] MAX_BYTES_RESET = 24'h01_0000;
  localparam int          FIFO_DEPTH      = 16;
  localparam int          FIFO_AW         = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  // One command from the front end: a whole header burst or one body byte.
  typedef struct packed {
    logic        is_header;
    logic [7:0]  data;
    logic        eop;
    logic [23:0] length;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] sync_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = SYNC_WORD[31:24];
      2'd1:    b = SYNC_WORD[23:16];
      2'd2:    b = SYNC_WORD[15:8];
      default: b = SYNC_WORD[7:0];
    endcase
    return b;
  endfunction

endpackage

/* hdl/slfd_front.sv */
// ----------------------------------------------------------------------------
// slfd_front
// Accepts received bytes, hunts for the sync word, gathers and checks the
// length, and issues header or body commands into the queue.
// ----------------------------------------------------------------------------
`include "sync_length_frame_deframer_assert.svh"

module slfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rx_valid_i,
  output logic                 rx_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic [23:0]          max_bytes_i,
  input  slfd_pkg::fifo_stat_t fifo_stat_i,
  output logic                 push_o,
  output slfd_pkg::cmd_t       cmd_o
);

  slfd_pkg::phase_e phase_q, phase_d;
  logic [31:0] win_q, win_d;
  logic [31:0] len_q, len_d;
  logic [23:0] cnt_q, cnt_d;

  logic        accept;
  logic [31:0] win_shift;
  logic [31:0] len_gather;
  logic [23:0] cnt_inc;
  logic        len_ok;
  logic        body_eop;

  assign rx_ready_o = !fifo_stat_i.full;
  assign accept     = rx_valid_i && rx_ready_o;
  assign win_shift  = {win_q[23:0], rx_byte_i};
  assign cnt_inc    = cnt_q + 24'd1;
  assign body_eop   = (cnt_inc == len_q[23:0]);

  // Length arrives little-endian; the capture is zero on entry.
  always_comb begin
    len_gather = len_q;
    case (cnt_q[1:0])
      2'd0:    len_gather[7:0]   = rx_byte_i;
      2'd1:    len_gather[15:8]  = rx_byte_i;
      2'd2:    len_gather[23:16] = rx_byte_i;
      default: len_gather[31:24] = rx_byte_i;
    endcase
  end

  assign len_ok = !(len_gather < 32'(slfd_pkg::HEADER_BYTES)) &&
                  !(len_gather > {8'd0, max_bytes_i});

  always_comb begin
    phase_d = phase_q;
    win_d   = win_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    cmd_o   = '{is_header: 1'b0, data: rx_byte_i, eop: 1'b0, length: len_q[23:0]};
    if (accept) begin
      case (phase_q)
        slfd_pkg::PH_BODY: begin
          cnt_d     = cnt_inc;
          push_o    = 1'b1;
          cmd_o.eop = body_eop;
          if (body_eop) begin
            phase_d = slfd_pkg::PH_HUNT;
            win_d   = '0;
            cnt_d   = '0;
          end
        end
        slfd_pkg::PH_LEN: begin
          win_d = win_shift;
          len_d = len_gather;
          cnt_d = cnt_inc;
          if (cnt_q[1:0] == 2'd3) begin
            if (len_ok) begin
              push_o          = 1'b1;
              cmd_o.is_header = 1'b1;
              cmd_o.length    = len_gather[23:0];
              phase_d         = slfd_pkg::PH_BODY;
              cnt_d           = 24'(slfd_pkg::WIRE_HDR_BYTES);
            end else begin
              // Rejected: the length bytes become the sync window.
              cnt_d = '0;
              if (win_shift == slfd_pkg::SYNC_WORD) begin
                len_d   = '0;
                phase_d = slfd_pkg::PH_LEN;
              end else begin
                phase_d = slfd_pkg::PH_HUNT;
              end
            end
          end
        end
        default: begin
          win_d   = win_shift;
          phase_d = slfd_pkg::PH_HUNT;
          if (win_shift == slfd_pkg::SYNC_WORD) begin
            phase_d = slfd_pkg::PH_LEN;
            len_d   = '0;
            cnt_d   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= slfd_pkg::PH_HUNT;
      win_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      win_q   <= win_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

  `SLFD_ASSERT_IMPL(a_len_cnt_small, clk_i, rst_ni, phase_q == slfd_pkg::PH_LEN, cnt_q < 24'd4)
  `SLFD_ASSERT_IMPL(a_body_cnt_below_len, clk_i, rst_ni, phase_q == slfd_pkg::PH_BODY, cnt_q < len_q[23:0])
  `SLFD_ASSERT_NEXT(a_eop_returns_hunt, clk_i, rst_ni, accept && (phase_q == slfd_pkg::PH_BODY) && body_eop, (phase_q == slfd_pkg::PH_HUNT) && (win_q == 32'd0))

endmodule

/* hdl/slfd_fifo.sv */
// ----------------------------------------------------------------------------
// slfd_fifo
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "sync_length_frame_deframer_assert.svh"

module slfd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  slfd_pkg::cmd_t       cmd_i,
  input  logic                 pop_i,
  output slfd_pkg::cmd_t       cmd_o,
  output slfd_pkg::fifo_stat_t stat_o
);

  slfd_pkg::cmd_t mem_q [slfd_pkg::FIFO_DEPTH];

  logic [slfd_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [slfd_pkg::FIFO_AW:0]   count_q;

  assign cmd_o        = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == (slfd_pkg::FIFO_AW + 1)'(slfd_pkg::FIFO_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `SLFD_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, !stat_o.full)
  `SLFD_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, !stat_o.empty)

endmodule

/* hdl/slfd_back.sv */
// ----------------------------------------------------------------------------
// slfd_back
// Drains queued commands into the output register: a header command becomes
// an eight-result burst, a body command a single result.
// ----------------------------------------------------------------------------
`include "sync_length_frame_deframer_assert.svh"

module slfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slfd_pkg::cmd_t       cmd_i,
  input  slfd_pkg::fifo_stat_t fifo_stat_i,
  output logic                 pop_o,
  output logic                 msg_valid_o,
  input  logic                 msg_ready_i,
  output logic [7:0]           data_byte_o,
  output logic                 start_of_message_o,
  output logic                 end_of_message_o,
  output logic [23:0]          message_length_o,
  output logic                 run_last_o
);

  localparam logic [2:0] LastBeat = 3'(slfd_pkg::WIRE_HDR_BYTES - 1);

  // Beats 0-3 carry the sync word, beats 4-7 the length, low byte first.
  // An accepted length never exceeds 24 bits, so its top byte is zero.
  function automatic logic [7:0] hdr_byte(input logic [2:0] beat, input logic [23:0] len);
    logic [7:0] b;
    if (!beat[2]) begin
      b = slfd_pkg::sync_byte(beat[1:0]);
    end else begin
      case (beat[1:0])
        2'd0:    b = len[7:0];
        2'd1:    b = len[15:8];
        2'd2:    b = len[23:16];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  logic        busy_q, busy_d;
  logic [2:0]  beat_q, beat_d;
  logic [23:0] hdr_len_q, hdr_len_d;

  logic        out_valid_q;
  logic [7:0]  out_data_q, out_data_d;
  logic        out_sop_q, out_sop_d;
  logic        out_eop_q, out_eop_d;
  logic [23:0] out_len_q, out_len_d;
  logic        out_last_q, out_last_d;

  logic out_free;
  logic load;

  assign out_free = !out_valid_q || msg_ready_i;
  assign pop_o    = out_free && !busy_q && !fifo_stat_i.empty;

  always_comb begin
    busy_d     = busy_q;
    beat_d     = beat_q;
    hdr_len_d  = hdr_len_q;
    load       = 1'b0;
    out_data_d = cmd_i.data;
    out_sop_d  = 1'b0;
    out_eop_d  = cmd_i.eop;
    out_len_d  = cmd_i.length;
    out_last_d = 1'b1;
    if (busy_q && out_free) begin
      load       = 1'b1;
      out_data_d = hdr_byte(beat_q, hdr_len_q);
      out_eop_d  = 1'b0;
      out_len_d  = hdr_len_q;
      out_last_d = (beat_q == LastBeat);
      beat_d     = beat_q + 3'd1;
      if (beat_q == LastBeat) begin
        busy_d = 1'b0;
      end
    end else if (pop_o) begin
      load = 1'b1;
      if (cmd_i.is_header) begin
        out_data_d = hdr_byte(3'd0, cmd_i.length);
        out_sop_d  = 1'b1;
        out_eop_d  = 1'b0;
        out_last_d = 1'b0;
        busy_d     = 1'b1;
        beat_d     = 3'd1;
        hdr_len_d  = cmd_i.length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (msg_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_len_q <= hdr_len_d;
    if (load) begin
      out_data_q <= out_data_d;
      out_sop_q  <= out_sop_d;
      out_eop_q  <= out_eop_d;
      out_len_q  <= out_len_d;
      out_last_q <= out_last_d;
    end
  end

  assign msg_valid_o        = out_valid_q;
  assign data_byte_o        = out_data_q;
  assign start_of_message_o = out_sop_q;
  assign end_of_message_o   = out_eop_q;
  assign message_length_o   = out_len_q;
  assign run_last_o         = out_last_q;

  `SLFD_ASSERT_IMPL(a_busy_beat_nonzero, clk_i, rst_ni, busy_q, beat_q != 3'd0)

endmodule

/* hdl/sync_length_frame_deframer.sv */
// ----------------------------------------------------------------------------
// sync_length_frame_deframer
// Finds sync-word framed, length-prefixed messages in a byte stream and
// emits their bytes with start and end marks.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the rx channel and never
// stalls it while the output side keeps taking results. A message is the
// sync word 0e 19 01 17, a 32-bit little-endian total length (header
// included), then the body. Lengths below 48 or above max_message_bytes are
// rejected; the four length bytes then form the new sync window and are
// tested at once. For an accepted length, the eight header bytes leave as a
// burst of eight results (run_last on the eighth), then each body byte gives
// one result. A sixteen-entry command queue between the byte classifier and
// the result generator absorbs the header burst; results come from its
// commands through the output register and leave at one per cycle while
// the msg side takes them. The queue can only fill, and rx_ready_o drop,
// when the msg side stalls. While the msg side keeps taking results, the
// sustained rate is one byte in and one result out per cycle, limited by
// the single output register. max_message_bytes is written through the
// cfg channel, which is always ready; write it only while the block is idle.

module sync_length_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel (max_message_bytes)
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_max_message_bytes_i,
  // Received byte channel
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Message result channel
  output logic        msg_valid_o,
  input  logic        msg_ready_i,
  output logic [7:0]  data_byte_o,
  output logic        start_of_message_o,
  output logic        end_of_message_o,
  output logic [23:0] message_length_o,
  output logic        run_last_o
);

  // Maximum message length register, loaded by each cfg transaction.
  logic [23:0] max_bytes_q;

  logic                 push;
  logic                 pop;
  slfd_pkg::cmd_t       front_cmd;
  slfd_pkg::cmd_t       head_cmd;
  slfd_pkg::fifo_stat_t fifo_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= slfd_pkg::MAX_BYTES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_max_message_bytes_i;
    end
  end

  // Front end: sync hunt, length capture and check, body byte counting.
  slfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .max_bytes_i (max_bytes_q),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  // Command queue: one entry per header or body transaction.
  slfd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (fifo_stat)
  );

  // Back end: header burst expansion and the output register.
  slfd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (head_cmd),
    .fifo_stat_i        (fifo_stat),
    .pop_o              (pop),
    .msg_valid_o        (msg_valid_o),
    .msg_ready_i        (msg_ready_i),
    .data_byte_o        (data_byte_o),
    .start_of_message_o (start_of_message_o),
    .end_of_message_o   (end_of_message_o),
    .message_length_o   (message_length_o),
    .run_last_o         (run_last_o)
  );

endmodule

/* bench/sync_length_frame_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_tb
// Drives byte streams with sync words, good and bad length fields and
// message bodies into the deframer. A shadow deframer predicts every
// message byte, and each result transaction is checked against it in order.
// ----------------------------------------------------------------------------

module sync_length_frame_deframer_tb;

  // The watchdog limit sits well above a long hold-off on the result side.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  // Bytes that cause no result may still be in flight once the last expected
  // result has come out.
  localparam int SETTLE_CYCLES  = 12;
  localparam int MAX_REPORTS    = 10;
  // Accepted message lengths stay short so that every frame is quick.
  localparam logic [31:0] LONGEST_FRAME = 32'd64;

  typedef struct {
    logic [7:0]  data;
    logic        sop;
    logic        eop;
    logic [23:0] len;
    logic        last;
  } msg_result_t;

  logic        clk_i;
  logic        rst_ni                  = 1'b0;
  logic        cfg_valid_i             = 1'b0;
  logic        cfg_ready_o;
  logic [23:0] cfg_max_message_bytes_i = '0;
  logic        rx_valid_i              = 1'b0;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i               = '0;
  logic        msg_valid_o;
  logic        msg_ready_i             = 1'b0;
  logic [7:0]  data_byte_o;
  logic        start_of_message_o;
  logic        end_of_message_o;
  logic [23:0] message_length_o;
  logic        run_last_o;

  // Shadow copy of the deframer state and its one register.
  logic [23:0]      max_len = slfd_pkg::MAX_BYTES_RESET;
  logic [31:0]      win     = '0;
  slfd_pkg::phase_e ph      = slfd_pkg::PH_HUNT;
  logic [31:0]      len_acc = '0;
  logic [23:0]      cnt     = '0;

  msg_result_t msg_expect_q[$];

  int items_sent     = 0;
  int mismatch_cnt   = 0;
  int stall_cycles   = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;

  sync_length_frame_deframer u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_max_message_bytes_i(cfg_max_message_bytes_i),
    .rx_valid_i             (rx_valid_i),
    .rx_ready_o             (rx_ready_o),
    .rx_byte_i              (rx_byte_i),
    .msg_valid_o            (msg_valid_o),
    .msg_ready_i            (msg_ready_i),
    .data_byte_o            (data_byte_o),
    .start_of_message_o     (start_of_message_o),
    .end_of_message_o       (end_of_message_o),
    .message_length_o       (message_length_o),
    .run_last_o             (run_last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow deframer
  // --------------------------------------------------------------------------

  function automatic void push_result(input logic [7:0] data, input logic sop,
                                      input logic eop, input logic last);
    msg_result_t r;
    r.data = data;
    r.sop  = sop;
    r.eop  = eop;
    r.len  = len_acc[23:0];
    r.last = last;
    msg_expect_q.push_back(r);
  endfunction

  // Advances the shadow state by one received byte and queues the message
  // bytes that this byte releases.
  function automatic void predict_deframe(input logic [7:0] b);
    logic eop;
    // Body bytes bypass the sync window entirely, so a sync word inside a
    // body never restarts the search.
    if (ph == slfd_pkg::PH_BODY) begin
      cnt = cnt + 24'd1;
      eop = (cnt == len_acc[23:0]);
      push_result(b, 1'b0, eop, 1'b1);
      if (eop) begin
        // The window is cleared, so four fresh bytes are needed to resync.
        ph  = slfd_pkg::PH_HUNT;
        win = '0;
        cnt = '0;
      end
      return;
    end
    win = {win[23:0], b};
    if (ph == slfd_pkg::PH_LEN) begin
      len_acc = len_acc | (32'(b) << (8 * cnt[1:0]));
      cnt     = cnt + 24'd1;
      if (cnt < 24'd4) return;
      if (len_acc < slfd_pkg::HEADER_BYTES || len_acc > {8'h00, max_len}) begin
        // A rejected length field is itself the new sync window.
        cnt = '0;
        if (win == slfd_pkg::SYNC_WORD) begin
          len_acc = '0;
          ph      = slfd_pkg::PH_LEN;
        end else begin
          ph = slfd_pkg::PH_HUNT;
        end
        return;
      end
      // The header leaves as a burst of eight: sync word, then the length
      // field in the order it arrived.
      for (int k = 0; k < 4; k++) begin
        push_result(slfd_pkg::SYNC_WORD[31 - 8 * k -: 8], (k == 0), 1'b0, 1'b0);
      end
      for (int k = 0; k < 4; k++) begin
        push_result(len_acc[8 * k +: 8], 1'b0, 1'b0, (k == 3));
      end
      ph  = slfd_pkg::PH_BODY;
      cnt = 24'd8;
      return;
    end
    ph = slfd_pkg::PH_HUNT;
    if (win == slfd_pkg::SYNC_WORD) begin
      ph      = slfd_pkg::PH_LEN;
      len_acc = '0;
      cnt     = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready pattern, hold-off and checking
  // --------------------------------------------------------------------------

  // The hold-off counter is loaded at a rising edge and counted down here at
  // falling edges, so the two never touch it in the same time step.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      msg_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      msg_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    msg_result_t want;
    if (rst_ni && msg_valid_o && msg_ready_i) begin
      if (msg_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("%0t ERROR: unexpected result data=%02h sop=%b eop=%b len=%0d last=%b",
                   $realtime, data_byte_o, start_of_message_o, end_of_message_o,
                   message_length_o, run_last_o);
        end
      end else begin
        want = msg_expect_q.pop_front();
        if (data_byte_o !== want.data || start_of_message_o !== want.sop ||
            end_of_message_o !== want.eop || message_length_o !== want.len ||
            run_last_o !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t ERROR: expected data=%02h sop=%b eop=%b len=%0d last=%b",
                     $realtime, want.data, want.sop, want.eop, want.len, want.last);
            $display("%0t        actual   data=%02h sop=%b eop=%b len=%0d last=%b",
                     $realtime, data_byte_o, start_of_message_o, end_of_message_o,
                     message_length_o, run_last_o);
          end
        end
      end
    end
  end

  // The watchdog restarts on any transaction on any of the three channels.
  always @(posedge clk_i) begin
    if (rst_ni && ((rx_valid_i && rx_ready_o) || (msg_valid_o && msg_ready_i) ||
                   (cfg_valid_i && cfg_ready_o))) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ERROR: no transaction for %0d cycles", $realtime, stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Each one starts and ends at a falling clock edge.
  // --------------------------------------------------------------------------

  // Sends one received byte. The valid line stays high from one byte to the
  // next unless the sender idles in between.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    predict_deframe(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_sync();
    for (int k = 0; k < 4; k++) send_byte(slfd_pkg::SYNC_WORD[31 - 8 * k -: 8]);
  endtask

  // The length field goes out least significant byte first.
  task automatic send_length(input logic [31:0] n);
    for (int k = 0; k < 4; k++) send_byte(n[8 * k +: 8]);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  // Sync word, length field and, where the length passes, a random body.
  // The body may hide a sync word, and may end on the first three sync bytes
  // followed by the fourth right after the message, which must not resync.
  task automatic send_frame(input logic [31:0] n);
    int   nb;
    int   pos;
    bit   embed;
    bit   tail;
    logic [7:0] b;
    send_sync();
    send_length(n);
    if (n >= slfd_pkg::HEADER_BYTES && n <= {8'h00, max_len}) begin
      nb    = int'(n) - 8;
      embed = ($urandom_range(2) == 0);
      tail  = ($urandom_range(3) == 0);
      pos   = $urandom_range(nb - 4);
      for (int i = 0; i < nb; i++) begin
        b = 8'($urandom);
        if (embed && i >= pos && i < pos + 4) begin
          b = slfd_pkg::SYNC_WORD[31 - 8 * (i - pos) -: 8];
        end
        if (tail && i >= nb - 3) b = slfd_pkg::SYNC_WORD[31 - 8 * (i - nb + 3) -: 8];
        send_byte(b);
      end
      if (tail) send_byte(slfd_pkg::SYNC_WORD[7:0]);
    end
  endtask

  // Frame lengths lean on the edges of the accepted range.
  function automatic logic [31:0] pick_frame_length();
    logic [31:0] top;
    top = ({8'h00, max_len} < LONGEST_FRAME) ? {8'h00, max_len} : LONGEST_FRAME;
    case ($urandom_range(11))
      0:       return slfd_pkg::HEADER_BYTES - 1;
      1:       return {8'h00, max_len} + 32'd1;
      2:       return {8'($urandom_range(255, 1)), 24'($urandom)};
      3:       return $urandom_range(slfd_pkg::HEADER_BYTES - 1);
      4:       return slfd_pkg::HEADER_BYTES;
      5:       return top;
      default: return $urandom_range(top, slfd_pkg::HEADER_BYTES);
    endcase
  endfunction

  // Mostly well-formed frames, with a little line noise between them.
  task automatic run_random_frames(input int budget);
    int first;
    first = items_sent;
    do begin
      if ($urandom_range(3) == 0) send_noise($urandom_range(6, 1));
      send_frame(pick_frame_length());
    end while (items_sent - first < budget);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    @(posedge clk_i);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    @(negedge clk_i);
  endtask

  // Waits until every expected result is out and bytes still in flight
  // have had time to settle.
  task automatic wait_until_quiet();
    rx_valid_i <= 1'b0;
    while (msg_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_bytes(input logic [23:0] value);
    wait_until_quiet();
    cfg_valid_i             <= 1'b1;
    cfg_max_message_bytes_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    max_len = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Rejected lengths at the reset limit of 65536: a length field that is
  // itself the sync word, a length just below the header size, the largest
  // possible length, and one just past the limit. A broken sync prefix
  // comes first.
  task automatic test_length_rejects();
    send_byte(slfd_pkg::SYNC_WORD[31:24]);
    send_byte(slfd_pkg::SYNC_WORD[23:16]);
    send_sync();
    send_length({slfd_pkg::SYNC_WORD[7:0], slfd_pkg::SYNC_WORD[15:8],
                 slfd_pkg::SYNC_WORD[23:16], slfd_pkg::SYNC_WORD[31:24]});
    send_length(slfd_pkg::HEADER_BYTES - 1);
    send_sync();
    send_length(32'hFFFF_FFFF);
    send_sync();
    send_length({8'h00, slfd_pkg::MAX_BYTES_RESET} + 32'd1);
  endtask

  task automatic test_reset_limit_frames();
    run_random_frames(30);
  endtask

  // With the limit equal to the header size only 48-byte messages pass.
  task automatic test_limit_at_header_size();
    write_max_bytes(24'(slfd_pkg::HEADER_BYTES));
    set_idling(53, 0);
    run_random_frames(30);
  endtask

  task automatic test_widest_limit();
    write_max_bytes(24'hFF_FFFF);
    set_idling(0, 53);
    run_random_frames(30);
  endtask

  // A limit below the header size rejects every frame.
  task automatic test_limit_below_header();
    write_max_bytes(24'd9);
    set_idling(13, 13);
    run_random_frames(20);
  endtask

  task automatic test_random_limit();
    write_max_bytes(24'($urandom_range(LONGEST_FRAME, slfd_pkg::HEADER_BYTES + 1)));
    set_idling(13, 13);
    run_random_frames(30);
  endtask

  // The result side holds off for a long stretch while a long message keeps
  // coming, so the command queue fills and the byte input must stall.
  task automatic test_output_backpressure();
    write_max_bytes(24'hFF_FFFF);
    set_idling(0, 0);
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    send_frame(32'd64);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_length_rejects();
    test_reset_limit_frames();
    test_limit_at_header_size();
    test_widest_limit();
    test_limit_below_header();
    test_random_limit();
    test_output_backpressure();

    wait_until_quiet();
    if (msg_expect_q.size() != 0) begin
      mismatch_cnt++;
      $display("%0t ERROR: %0d expected results never arrived", $realtime,
               msg_expect_q.size());
    end
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sync_length_frame_deframer.f */
+incdir+hdl
hdl/slfd_pkg.sv
hdl/slfd_front.sv
hdl/slfd_fifo.sv
hdl/slfd_back.sv
hdl/sync_length_frame_deframer.sv
bench/sync_length_frame_deframer_tb.sv
